>>> rtl/psd_pkg.sv
// Shared widths, case codes and pipeline payload types of the point-segment distance block.
`default_nettype none
package psd_pkg;

	// Fixed field and datapath widths.
	localparam int COORD_W = 24;
	localparam int DIFF_W  = 25;
	localparam int LEN_W   = 50;
	localparam int NUM_W   = 51;
	localparam int AXIS_W  = 26;
	localparam int SQ_W    = 52;
	localparam int DIST_W  = 49;
	localparam int PARAM_W = 17;

	// Which point of the segment is nearest.
	typedef enum logic [1:0] {
		CASE_ZERO     = 2'd0,
		CASE_BEFORE   = 2'd1,
		CASE_PAST     = 2'd2,
		CASE_INTERIOR = 2'd3
	} case_t;

	// Coordinate differences carried down the pipeline.
	typedef struct packed {
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy;
		logic signed [DIFF_W-1:0] wx;
		logic signed [DIFF_W-1:0] wy;
		logic signed [DIFF_W-1:0] ux;
		logic signed [DIFF_W-1:0] uy;
	} vec_t;

	// Differences plus the decided case.
	typedef struct packed {
		case_t kind;
		vec_t  v;
	} side_t;

endpackage
`default_nettype wire

>>> rtl/point_segment_distance_squared.sv
// Top level: squared distance from a point to a line segment, one transaction per clock.
// A result passes the front-end, divider and back-end register stages before done strobes.
// Throughput: one transaction per clock; the quotient takes one pipeline stage per bit.
// busy stays low, since the pipeline never stalls and the receiver cannot hold results.
// Reset clears only the valid bits, so no stale result is strobed after reset.
`default_nettype none
module point_segment_distance_squared #(
	parameter int T_FRAC = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic signed [psd_pkg::COORD_W-1:0]  point_x,
	input  wire logic signed [psd_pkg::COORD_W-1:0]  point_y,
	input  wire logic signed [psd_pkg::COORD_W-1:0]  start_x,
	input  wire logic signed [psd_pkg::COORD_W-1:0]  start_y,
	input  wire logic signed [psd_pkg::COORD_W-1:0]  end_x,
	input  wire logic signed [psd_pkg::COORD_W-1:0]  end_y,
	output logic                                     done,
	output logic [psd_pkg::DIST_W-1:0]               distance_squared,
	output logic [1:0]                               nearest_case,
	output logic [psd_pkg::PARAM_W-1:0]              projection_param
);

	localparam int LAT = T_FRAC + 8;

	logic                      f_valid, d_valid;
	psd_pkg::side_t            f_side, d_side;
	logic [psd_pkg::LEN_W-1:0] f_rem, f_den;
	logic                      f_q0;
	logic [T_FRAC:0]           d_tq;

	// The pipeline always advances.
	assign busy = 1'b0;

	psd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.point_x   (point_x),
		.point_y   (point_y),
		.start_x   (start_x),
		.start_y   (start_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.out_valid (f_valid),
		.out_side  (f_side),
		.out_rem   (f_rem),
		.out_den   (f_den),
		.out_q0    (f_q0)
	);

	psd_div #(.T_FRAC(T_FRAC)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_side   (f_side),
		.in_rem    (f_rem),
		.in_den    (f_den),
		.in_q0     (f_q0),
		.out_valid (d_valid),
		.out_side  (d_side),
		.out_tq    (d_tq)
	);

	psd_dist #(.T_FRAC(T_FRAC)) u_dist (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (d_valid),
		.in_side          (d_side),
		.in_tq            (d_tq),
		.done             (done),
		.distance_squared (distance_squared),
		.nearest_case     (nearest_case),
		.projection_param (projection_param)
	);

	// Every accepted transaction yields exactly one result, strobed on done.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("accepted transaction produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##LAT !done)
		else $error("result strobed without an accepted transaction");

	// End-point cases report a parameter of zero or one.
	a_param_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (nearest_case == psd_pkg::CASE_ZERO || nearest_case == psd_pkg::CASE_BEFORE)
		|-> projection_param == '0)
		else $error("nonzero parameter for a start end-point result");

	a_param_one: assert property (@(posedge clk) disable iff (!arst_n)
		done && nearest_case == psd_pkg::CASE_PAST
		|-> projection_param == psd_pkg::PARAM_W'(64'd1 << T_FRAC))
		else $error("parameter is not one for a far end-point result");

endmodule
`default_nettype wire

>>> rtl/psd_front.sv
// Front end: coordinate differences, dot products, case decode and first quotient bit.
`default_nettype none
module psd_front (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	input  wire logic signed [psd_pkg::COORD_W-1:0]   point_x,
	input  wire logic signed [psd_pkg::COORD_W-1:0]   point_y,
	input  wire logic signed [psd_pkg::COORD_W-1:0]   start_x,
	input  wire logic signed [psd_pkg::COORD_W-1:0]   start_y,
	input  wire logic signed [psd_pkg::COORD_W-1:0]   end_x,
	input  wire logic signed [psd_pkg::COORD_W-1:0]   end_y,
	output logic                                      out_valid,
	output psd_pkg::side_t                            out_side,
	output logic [psd_pkg::LEN_W-1:0]                 out_rem,
	output logic [psd_pkg::LEN_W-1:0]                 out_den,
	output logic                                      out_q0
);

	logic           valid_s1, valid_s2, valid_s3, valid_s4;
	psd_pkg::vec_t  vec_s1, vec_s2, vec_s3;
	psd_pkg::side_t side_s4;

	logic signed [psd_pkg::LEN_W-1:0] pdx_s2, pdy_s2, pwx_s2, pwy_s2;
	logic        [psd_pkg::LEN_W-1:0] len2_s3;
	logic signed [psd_pkg::NUM_W-1:0] num_s3;
	logic        [psd_pkg::LEN_W-1:0] rem_s4, den_s4;
	logic                             q0_s4;

	psd_pkg::case_t                 kind;
	logic [psd_pkg::LEN_W-1:0]      rem_init;
	logic                           q0;
	logic signed [psd_pkg::NUM_W-1:0] sum_len;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Stage 1: segment direction, offset from start and offset from end.
	always_ff @(posedge clk) begin
		vec_s1.dx <= {end_x[23], end_x} - {start_x[23], start_x};
		vec_s1.dy <= {end_y[23], end_y} - {start_y[23], start_y};
		vec_s1.wx <= {point_x[23], point_x} - {start_x[23], start_x};
		vec_s1.wy <= {point_y[23], point_y} - {start_y[23], start_y};
		vec_s1.ux <= {point_x[23], point_x} - {end_x[23], end_x};
		vec_s1.uy <= {point_y[23], point_y} - {end_y[23], end_y};
	end

	// Stage 2: the four products.
	always_ff @(posedge clk) begin
		pdx_s2 <= vec_s1.dx * vec_s1.dx;
		pdy_s2 <= vec_s1.dy * vec_s1.dy;
		pwx_s2 <= vec_s1.wx * vec_s1.dx;
		pwy_s2 <= vec_s1.wy * vec_s1.dy;
		vec_s2 <= vec_s1;
	end

	// Stage 3: squared length and dot product.
	assign sum_len = psd_pkg::NUM_W'(pdx_s2) + psd_pkg::NUM_W'(pdy_s2);

	always_ff @(posedge clk) begin
		len2_s3 <= sum_len[psd_pkg::LEN_W-1:0];
		num_s3  <= psd_pkg::NUM_W'(pwx_s2) + psd_pkg::NUM_W'(pwy_s2);
		vec_s3  <= vec_s2;
	end

	// Case decode and the integer bit of the quotient.
	always_comb begin
		if (len2_s3 == '0) begin
			kind = psd_pkg::CASE_ZERO;
		end else if (num_s3[psd_pkg::NUM_W-1]) begin
			kind = psd_pkg::CASE_BEFORE;
		end else if (num_s3[psd_pkg::LEN_W-1:0] > len2_s3) begin
			kind = psd_pkg::CASE_PAST;
		end else begin
			kind = psd_pkg::CASE_INTERIOR;
		end
		rem_init = (kind == psd_pkg::CASE_INTERIOR) ? num_s3[psd_pkg::LEN_W-1:0] : '0;
		q0       = (rem_init >= len2_s3);
	end

	// Stage 4: case and divider seed.
	always_ff @(posedge clk) begin
		side_s4.kind <= kind;
		side_s4.v    <= vec_s3;
		rem_s4       <= q0 ? (rem_init - len2_s3) : rem_init;
		den_s4       <= len2_s3;
		q0_s4        <= q0;
	end

	assign out_valid = valid_s4;
	assign out_side  = side_s4;
	assign out_rem   = rem_s4;
	assign out_den   = den_s4;
	assign out_q0    = q0_s4;

endmodule
`default_nettype wire

>>> rtl/psd_div.sv
// Pipelined restoring divider: one fraction bit of the projection parameter per stage.
`default_nettype none
module psd_div #(
	parameter int T_FRAC = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire psd_pkg::side_t                in_side,
	input  wire logic [psd_pkg::LEN_W-1:0]     in_rem,
	input  wire logic [psd_pkg::LEN_W-1:0]     in_den,
	input  wire logic                          in_q0,
	output logic                               out_valid,
	output psd_pkg::side_t                     out_side,
	output logic [T_FRAC:0]                    out_tq
);

	localparam int TQW = T_FRAC + 1;

	// Index zero is the stage input, index n is the register of stage n.
	logic                      valid_sn [0:T_FRAC];
	psd_pkg::side_t            side_sn  [0:T_FRAC];
	logic [psd_pkg::LEN_W-1:0] rem_sn   [0:T_FRAC];
	logic [psd_pkg::LEN_W-1:0] den_sn   [0:T_FRAC];
	logic [TQW-1:0]            q_sn     [0:T_FRAC];

	assign valid_sn[0] = in_valid;
	assign side_sn[0]  = in_side;
	assign rem_sn[0]   = in_rem;
	assign den_sn[0]   = in_den;
	assign q_sn[0]     = TQW'(in_q0);

	for (genvar i = 0; i < T_FRAC; i++) begin : g_step
		logic [psd_pkg::LEN_W:0] shifted;
		logic                    fits;

		// Shift the remainder and try to subtract the divisor.
		assign shifted = {rem_sn[i], 1'b0};
		assign fits    = (shifted >= {1'b0, den_sn[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sn[i+1] <= 1'b0;
			end else begin
				valid_sn[i+1] <= valid_sn[i];
			end
		end

		always_ff @(posedge clk) begin
			rem_sn[i+1]  <= fits ? psd_pkg::LEN_W'(shifted - {1'b0, den_sn[i]})
			                     : psd_pkg::LEN_W'(shifted);
			den_sn[i+1]  <= den_sn[i];
			q_sn[i+1]    <= {q_sn[i][TQW-2:0], fits};
			side_sn[i+1] <= side_sn[i];
		end
	end

	assign out_valid = valid_sn[T_FRAC];
	assign out_side  = side_sn[T_FRAC];
	assign out_tq    = q_sn[T_FRAC];

endmodule
`default_nettype wire

>>> rtl/psd_dist.sv
// Back end: projected offset, chosen difference vector, squares and the result register.
`default_nettype none
module psd_dist #(
	parameter int T_FRAC = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire psd_pkg::side_t                in_side,
	input  wire logic [T_FRAC:0]               in_tq,
	output logic                               done,
	output logic [psd_pkg::DIST_W-1:0]         distance_squared,
	output logic [1:0]                         nearest_case,
	output logic [psd_pkg::PARAM_W-1:0]        projection_param
);

	localparam int TQW = T_FRAC + 1;
	localparam int MW  = TQW + psd_pkg::DIFF_W;
	localparam int XW  = (TQW > psd_pkg::PARAM_W) ? TQW : psd_pkg::PARAM_W;
	localparam logic [TQW-1:0] T_ONE = TQW'(1) << T_FRAC;

	logic           valid_s1, valid_s2, valid_s3, done_q;
	psd_pkg::side_t side_s1;
	psd_pkg::case_t kind_s2, kind_s3, kind_q;
	logic [TQW-1:0] tq_s1;
	logic [MW-1:0]  magx_s1, magy_s1;
	logic signed [psd_pkg::AXIS_W-1:0] ax_s2, ay_s2;
	logic [XW-1:0]  param_s2, param_s3;
	logic signed [psd_pkg::SQ_W-1:0]   sqx_s3, sqy_s3;
	logic [psd_pkg::DIST_W-1:0]        dist_q;
	logic [psd_pkg::PARAM_W-1:0]       param_q;

	logic [psd_pkg::DIFF_W-1:0]        adx, ady, offx, offy;
	logic signed [psd_pkg::AXIS_W-1:0] wxe, wye, ax, ay;
	logic [TQW-1:0]                    tsel;
	logic [psd_pkg::SQ_W:0]            sq_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			done_q   <= valid_s3;
		end
	end

	// Magnitudes of the segment direction.
	assign adx = in_side.v.dx[psd_pkg::DIFF_W-1] ? psd_pkg::DIFF_W'(-in_side.v.dx)
	                                             : psd_pkg::DIFF_W'(in_side.v.dx);
	assign ady = in_side.v.dy[psd_pkg::DIFF_W-1] ? psd_pkg::DIFF_W'(-in_side.v.dy)
	                                             : psd_pkg::DIFF_W'(in_side.v.dy);

	// Stage 1: parameter times direction magnitude.
	always_ff @(posedge clk) begin
		magx_s1 <= MW'(in_tq) * MW'(adx);
		magy_s1 <= MW'(in_tq) * MW'(ady);
		tq_s1   <= in_tq;
		side_s1 <= in_side;
	end

	// Pick the vector from the nearest point to the query point.
	always_comb begin
		offx = magx_s1[T_FRAC +: psd_pkg::DIFF_W];
		offy = magy_s1[T_FRAC +: psd_pkg::DIFF_W];
		wxe  = {side_s1.v.wx[psd_pkg::DIFF_W-1], side_s1.v.wx};
		wye  = {side_s1.v.wy[psd_pkg::DIFF_W-1], side_s1.v.wy};
		case (side_s1.kind)
			psd_pkg::CASE_INTERIOR: begin
				ax   = side_s1.v.dx[psd_pkg::DIFF_W-1] ? wxe + $signed({1'b0, offx})
				                                       : wxe - $signed({1'b0, offx});
				ay   = side_s1.v.dy[psd_pkg::DIFF_W-1] ? wye + $signed({1'b0, offy})
				                                       : wye - $signed({1'b0, offy});
				tsel = tq_s1;
			end
			psd_pkg::CASE_PAST: begin
				ax   = {side_s1.v.ux[psd_pkg::DIFF_W-1], side_s1.v.ux};
				ay   = {side_s1.v.uy[psd_pkg::DIFF_W-1], side_s1.v.uy};
				tsel = T_ONE;
			end
			default: begin
				ax   = wxe;
				ay   = wye;
				tsel = '0;
			end
		endcase
	end

	// Stage 2: difference vector and parameter.
	always_ff @(posedge clk) begin
		ax_s2    <= ax;
		ay_s2    <= ay;
		param_s2 <= XW'(tsel);
		kind_s2  <= side_s1.kind;
	end

	// Stage 3: per-axis squares.
	always_ff @(posedge clk) begin
		sqx_s3   <= ax_s2 * ax_s2;
		sqy_s3   <= ay_s2 * ay_s2;
		param_s3 <= param_s2;
		kind_s3  <= kind_s2;
	end

	assign sq_sum = (psd_pkg::SQ_W+1)'(sqx_s3) + (psd_pkg::SQ_W+1)'(sqy_s3);

	// Result register.
	always_ff @(posedge clk) begin
		dist_q  <= sq_sum[psd_pkg::DIST_W-1:0];
		param_q <= param_s3[psd_pkg::PARAM_W-1:0];
		kind_q  <= kind_s3;
	end

	assign done             = done_q;
	assign distance_squared = dist_q;
	assign nearest_case     = kind_q;
	assign projection_param = param_q;

endmodule
`default_nettype wire
